[rtl/mhws_pkg.sv]
// Types, constants and hash helper functions for the MinHash window signature block.
// Depends on nothing; imported by minhash_window_signature.
package mhws_pkg;

   localparam int HASH_W  = 32;
   localparam int IDX_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int WIN_LEN = 16;

   localparam logic [HASH_W-1:0] MM_C1     = 32'hcc9e2d51;
   localparam logic [HASH_W-1:0] MM_C2     = 32'h1b873593;
   localparam logic [HASH_W-1:0] MM_ADD    = 32'he6546b64;
   localparam logic [HASH_W-1:0] MM_F1     = 32'h85ebca6b;
   localparam logic [HASH_W-1:0] MM_F2     = 32'hc2b2ae35;
   localparam logic [HASH_W-1:0] BASE_SEED = 32'h12345678;
   localparam logic [HASH_W-1:0] SEED_STEP = 32'h9e3779b9;
   localparam logic [HASH_W-1:0] ALL_ONES  = 32'hffffffff;
   localparam logic [HASH_W-1:0] LEN_WINDOW = 32'd16;
   localparam logic [HASH_W-1:0] LEN_WORD   = 32'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_message;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  word_index;
      logic [HASH_W-1:0] min_hash;
      logic              last_word;
   } rsp_type;

   // Combine step of one block: xor with the key, rotate left by 13, times 5, plus the constant.
   function automatic logic [HASH_W-1:0] mix_h(input logic [HASH_W-1:0] h,
                                               input logic [HASH_W-1:0] k2);
      logic [HASH_W-1:0] r;
      r = h ^ k2;
      r = {r[18:0], r[31:19]};
      return r + {r[29:0], 2'b00} + MM_ADD;
   endfunction

   function automatic logic [HASH_W-1:0] rotl15(input logic [HASH_W-1:0] x);
      return {x[16:0], x[31:17]};
   endfunction

   // Finalizer pieces around the two multiplications.
   function automatic logic [HASH_W-1:0] fin_pre(input logic [HASH_W-1:0] x,
                                                 input logic [HASH_W-1:0] len);
      logic [HASH_W-1:0] y;
      y = x ^ len;
      return y ^ (y >> 16);
   endfunction

   function automatic logic [HASH_W-1:0] fin_mid(input logic [HASH_W-1:0] x);
      return x ^ (x >> 13);
   endfunction

   function automatic logic [HASH_W-1:0] fin_post(input logic [HASH_W-1:0] x);
      return x ^ (x >> 16);
   endfunction

endpackage

[rtl/mhws_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module mhws_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/minhash_window_signature.sv]
// Top level of the MinHash window signature block: window, hash sequencer and signature store.
// Depends on mhws_pkg and mhws_ram.
//
// The block takes a message one byte per transaction (start high while busy is low) and keeps
// the last 16 bytes. Whenever the byte count reaches a multiple of 8 that is at least 16, the
// window is hashed with MurmurHash3 x86_32 under seed 0x12345678, and that base hash is hashed
// again under the seeds j*0x9e3779b9 for every signature word j; each word keeps its minimum.
// A byte that starts no hash and does not end the message leaves busy low. A byte that starts
// a hash holds busy high through the base hash on the shared key and finalizer multipliers,
// then through the signature words, one per cycle through the finalizer pipeline, and then
// through the drain of that pipeline into the signature memory. The byte marked end_of_message is
// taken in first (including any hash it starts); then the block reads the signature memory one
// word per cycle and emits SIG_WORDS result transactions, one per cycle on consecutive cycles,
// each shown for exactly one cycle with rsp_valid high. The receiver cannot stall: it must take
// each result in the cycle it appears. busy stays high until the cycle that shows the last word,
// the signature returns to all ones and the counters clear, so the first byte of the next
// message can be taken at the same edge that takes the last word.
// Words that were never lowered read as all ones through per-word valid flags, so no clearing
// pass over the memory is needed after reset or between messages.
module minhash_window_signature #(
   parameter int SIG_WORDS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mhws_pkg::req_type req_data,
   output logic              rsp_valid,
   output mhws_pkg::rsp_type rsp_data
);

   import mhws_pkg::*;

   localparam int AW = (SIG_WORDS > 1) ? $clog2(SIG_WORDS) : 1;
   localparam logic [AW-1:0] LAST_J = AW'(SIG_WORDS - 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BASE  = 3'd1;
   localparam logic [2:0] S_SIG   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   // Steps of the base hash schedule.
   localparam logic [3:0] ST_SEED     = 4'd0;
   localparam logic [3:0] ST_MIX_FST  = 4'd2;
   localparam logic [3:0] ST_MIX_LST  = 4'd5;
   localparam logic [3:0] ST_KEY_BASE = 4'd9;
   localparam logic [3:0] ST_KEY_DONE = 4'd10;

   logic [2:0]        state_ff, state_in;
   logic [3:0]        step_ff, step_in;
   logic [AW-1:0]     j_ff, j_in;
   logic [2:0]        phase_ff, phase_in;
   logic [1:0]        filled_ff, filled_in;
   logic              eom_ff, eom_in;
   logic [SIG_WORDS-1:0] valid_ff, valid_in;

   logic [BYTE_W-1:0] win_ff [WIN_LEN];
   logic [BYTE_W-1:0] win_in [WIN_LEN];

   logic [HASH_W-1:0] kc1_ff, kc1_in;
   logic [HASH_W-1:0] kc2_ff, kc2_in;
   logic [HASH_W-1:0] h_ff, h_in;
   logic [HASH_W-1:0] seed_ff, seed_in;
   logic [HASH_W-1:0] fa_ff, fa_in;
   logic [HASH_W-1:0] fb_ff, fb_in;
   logic [HASH_W-1:0] fc_ff, fc_in;

   // Finalizer pipeline tags for the per-word hashes.
   logic              v1_ff, v1_in, v2_ff, v3_ff;
   logic [AW-1:0]     j1_ff, j1_in, j2_ff, j3_ff;

   // Output stage.
   logic              ev_ff, ev_in;
   logic [AW-1:0]     eidx_ff, eidx_in;
   logic              elast_ff, elast_in;
   logic              evalid_ff, evalid_in;

   logic              accept;
   logic [2:0]        phase_inc;
   logic [1:0]        fill_inc;
   logic              hash_start;
   logic [HASH_W-1:0] word_sel;
   logic [HASH_W-1:0] hash_out;
   logic [HASH_W-1:0] old_min;
   logic              mem_we;
   logic [AW-1:0]     rd_addr;
   logic [HASH_W-1:0] rd_data;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign phase_inc = phase_ff + 3'd1;
   assign fill_inc  = (phase_inc != 3'd0) ? filled_ff :
                      (filled_ff == 2'd2) ? filled_ff : filled_ff + 2'd1;
   assign hash_start = (phase_inc == 3'd0) && (fill_inc == 2'd2);

   // Window word for the base hash; byte 0 of each group is the least significant.
   always_comb begin
      unique case (step_ff[1:0])
         2'd0:    word_sel = {win_ff[3],  win_ff[2],  win_ff[1],  win_ff[0]};
         2'd1:    word_sel = {win_ff[7],  win_ff[6],  win_ff[5],  win_ff[4]};
         2'd2:    word_sel = {win_ff[11], win_ff[10], win_ff[9],  win_ff[8]};
         default: word_sel = {win_ff[15], win_ff[14], win_ff[13], win_ff[12]};
      endcase
   end

   // The finalizer runs every cycle. In the base phase it carries the base hash (length 16);
   // in the signature phase it takes one seeded hash (length 4) per cycle.
   assign fa_in    = (state_ff == S_SIG) ? fin_pre(mix_h(seed_ff, kc2_ff), LEN_WORD)
                                         : fin_pre(h_ff, LEN_WINDOW);
   assign fb_in    = fa_ff * MM_F1;
   assign fc_in    = fin_mid(fb_ff) * MM_F2;
   assign hash_out = fin_post(fc_ff);

   // Key mixing: the window words during the base hash, then the base hash itself, which
   // is the common key of every seeded hash and is held in kc2 afterwards.
   assign kc1_in = (state_ff != S_BASE) ? kc1_ff :
                   ((step_ff == ST_KEY_BASE) ? hash_out : word_sel) * MM_C1;
   assign kc2_in = (state_ff == S_BASE) ? rotl15(kc1_ff) * MM_C2 : kc2_ff;

   always_comb begin
      h_in = h_ff;
      if (state_ff == S_BASE) begin
         if (step_ff == ST_SEED) begin
            h_in = BASE_SEED;
         end else if (step_ff >= ST_MIX_FST && step_ff <= ST_MIX_LST) begin
            h_in = mix_h(h_ff, kc2_ff);
         end
      end
   end

   // Read-modify-write of the signature: the read is issued from the j2 stage, ahead of j3, so that the
   // stored word arrives together with the finished hash.
   assign old_min = valid_ff[j3_ff] ? rd_data : ALL_ONES;
   assign mem_we  = v3_ff && (hash_out < old_min);
   assign rd_addr = (state_ff == S_EMIT) ? j_ff : j2_ff;

   mhws_ram #(
      .WIDTH  (HASH_W),
      .DEPTH  (SIG_WORDS),
      .ADDR_W (AW)
   ) u_sig_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (j3_ff),
      .wr_data (hash_out),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      j_in      = j_ff;
      phase_in  = phase_ff;
      filled_in = filled_ff;
      eom_in    = eom_ff;
      valid_in  = valid_ff;
      seed_in   = seed_ff;
      win_in    = win_ff;
      v1_in     = 1'b0;
      j1_in     = j_ff;
      ev_in     = 1'b0;
      eidx_in   = j_ff;
      elast_in  = (j_ff == LAST_J);
      evalid_in = valid_ff[j_ff];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               for (int i = 0; i < WIN_LEN - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[WIN_LEN-1] = req_data.data_byte;
               eom_in    = req_data.end_of_message;
               phase_in  = phase_inc;
               filled_in = fill_inc;
               if (req_data.end_of_message) begin
                  phase_in  = 3'd0;
                  filled_in = 2'd0;
               end
               j_in = '0;
               if (hash_start) begin
                  state_in = S_BASE;
                  step_in  = ST_SEED;
               end else if (req_data.end_of_message) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_BASE: begin
            step_in = step_ff + 4'd1;
            if (step_ff == ST_KEY_DONE) begin
               state_in = S_SIG;
               seed_in  = '0;
               j_in     = '0;
            end
         end
         S_SIG: begin
            v1_in   = 1'b1;
            seed_in = seed_ff + SEED_STEP;
            j_in    = j_ff + AW'(1);
            if (j_ff == LAST_J) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               j_in     = '0;
               state_in = eom_ff ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            ev_in = 1'b1;
            j_in  = j_ff + AW'(1);
            if (j_ff == LAST_J) begin
               valid_in = '0;
               eom_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (mem_we) begin
         valid_in[j3_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= '0;
         j_ff      <= '0;
         phase_ff  <= '0;
         filled_ff <= '0;
         eom_ff    <= 1'b0;
         valid_ff  <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         ev_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         j_ff      <= j_in;
         phase_ff  <= phase_in;
         filled_ff <= filled_in;
         eom_ff    <= eom_in;
         valid_ff  <= valid_in;
         v1_ff     <= v1_in;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         ev_ff     <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff    <= win_in;
      kc1_ff    <= kc1_in;
      kc2_ff    <= kc2_in;
      h_ff      <= h_in;
      seed_ff   <= seed_in;
      fa_ff     <= fa_in;
      fb_ff     <= fb_in;
      fc_ff     <= fc_in;
      j1_ff     <= j1_in;
      j2_ff     <= j1_ff;
      j3_ff     <= j2_ff;
      eidx_ff   <= eidx_in;
      elast_ff  <= elast_in;
      evalid_ff <= evalid_in;
   end

   assign rsp_valid           = ev_ff;
   assign rsp_data.word_index = IDX_W'(eidx_ff);
   assign rsp_data.min_hash   = evalid_ff ? rd_data : ALL_ONES;
   assign rsp_data.last_word  = elast_ff;

endmodule
